### rtl/core/sliding_window_median_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sliding window median block
// Shared property forms, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MEDIAN_ASSERT_SVH
`define SLIDING_WINDOW_MEDIAN_ASSERT_SVH

// Same-cycle implication.
`define SWM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SWM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/swm_pkg.sv
// ----------------------------------------------------------------------------
// Sliding window median package
// Shared defaults, register codes, sequencer states and cell control.
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int MAX_WINDOW_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int              WINDOW_SIZE_W   = 7;
  localparam logic [6:0]      WINDOW_SIZE_RST = 7'd3;

  // Register index taken from paddr[2].
  localparam logic REG_WINDOW_SIZE = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RANK,
    ST_COLLECT,
    ST_DONE
  } swm_state_t;

  typedef struct packed {
    logic shift;    // new sample enters the window chain
    logic load;     // copy window into the compare chains, clear rank and sum
    logic rank;     // compare and move the compare chains one cell
    logic collect;  // move the partial sum one cell toward cell 0
  } swm_cell_ctl_t;

endpackage

### rtl/core/swm_in_if.sv
// ----------------------------------------------------------------------------
// Sample input channel
// Valid/ready channel carrying one sample and its start flag per item.
// ----------------------------------------------------------------------------
interface swm_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          start_req;

  modport source (output valid, output sample, output start_req, input ready);
  modport sink   (input valid, input sample, input start_req, output ready);
endinterface

### rtl/core/swm_out_if.sv
// ----------------------------------------------------------------------------
// Median output channel
// Valid/ready channel carrying twice the window median per item.
// ----------------------------------------------------------------------------
interface swm_out_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                        valid;
  logic                        ready;
  logic signed [SAMPLE_BITS:0] median_twice;

  modport source (output valid, output median_twice, input ready);
  modport sink   (input valid, input median_twice, output ready);
endinterface

### rtl/core/swm_cell.sv
// ----------------------------------------------------------------------------
// Median chain cell
// Holds one window sample, counts its rank against samples passing on two
// compare chains, and adds its share into the partial sum chain.
// ----------------------------------------------------------------------------
module swm_cell
  import swm_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int RANK_W      = 6
) (
  input  logic                          clk,
  input  swm_cell_ctl_t                 ctl,
  input  logic                          mem,
  input  logic [RANK_W-1:0]             lo_rank,
  input  logic [RANK_W-1:0]             hi_rank,
  input  logic signed [SAMPLE_BITS-1:0] left_win,
  input  logic                          left_mem,
  input  logic signed [SAMPLE_BITS-1:0] left_fwd,
  input  logic                          left_fwd_ok,
  input  logic signed [SAMPLE_BITS-1:0] right_win,
  input  logic                          right_mem,
  input  logic signed [SAMPLE_BITS-1:0] right_bwd,
  input  logic                          right_bwd_ok,
  input  logic signed [SAMPLE_BITS:0]   right_acc,
  output logic signed [SAMPLE_BITS-1:0] win,
  output logic signed [SAMPLE_BITS-1:0] fwd,
  output logic                          fwd_ok,
  output logic signed [SAMPLE_BITS-1:0] bwd,
  output logic                          bwd_ok,
  output logic signed [SAMPLE_BITS:0]   acc
);

  logic [RANK_W-1:0]             rank;
  logic                          inc_fwd;
  logic                          inc_bwd;
  logic signed [SAMPLE_BITS:0]   win_ext;
  logic signed [SAMPLE_BITS:0]   part_lo;
  logic signed [SAMPLE_BITS:0]   part_hi;

  // Newer samples on equal values count as smaller, so every rank is unique.
  assign inc_fwd = fwd_ok && (fwd <= win);
  assign inc_bwd = bwd_ok && (bwd < win);

  assign win_ext = $signed({win[SAMPLE_BITS-1], win});
  assign part_lo = (mem && rank == lo_rank) ? win_ext : '0;
  assign part_hi = (mem && rank == hi_rank) ? win_ext : '0;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      win <= left_win;
    end
    if (ctl.load) begin
      fwd    <= left_win;
      fwd_ok <= left_mem;
      bwd    <= right_win;
      bwd_ok <= right_mem;
      rank   <= '0;
      acc    <= '0;
    end else begin
      if (ctl.rank) begin
        fwd    <= left_fwd;
        fwd_ok <= left_fwd_ok;
        bwd    <= right_bwd;
        bwd_ok <= right_bwd_ok;
        rank   <= rank + RANK_W'(inc_fwd) + RANK_W'(inc_bwd);
      end
      if (ctl.collect) begin
        acc <= right_acc + part_lo + part_hi;
      end
    end
  end

endmodule

### rtl/core/sliding_window_median.sv
// ----------------------------------------------------------------------------
// Sliding window median filter
// Keeps the newest samples in a chain of cells and returns twice the
// median of the last window_size samples.
//
//   channel   dir  handshake            payload
//   in_ch     in   valid / ready        sample, start_req
//   out_ch    out  valid / ready        median_twice
//   apb       in   psel/penable/pready  window_size at byte 0
//
// An item that completes no window is only shifted into the chain. An item
// that gives a result passes through the accept, a load of the compare
// chains, rank steps while samples travel between neighboring cells,
// steps of the sum chain toward cell 0, and the handover to the output
// register. The output register holds a result while the next item is
// accepted; a stalled result only holds the block when the following
// result is ready. Reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module sliding_window_median
  import swm_pkg::*;
#(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  swm_in_if.sink      in_ch,
  swm_out_if.source   out_ch
);

  localparam int KW     = $clog2(MAX_WINDOW + 1);
  localparam int CW     = (KW > WINDOW_SIZE_W) ? KW : WINDOW_SIZE_W;
  localparam int RANK_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int OW     = SAMPLE_BITS + 1;

  `include "sliding_window_median_assert.svh"

  swm_state_t state, state_next;

  logic [WINDOW_SIZE_W-1:0] window_size;
  logic [KW-1:0]            fill_count;
  logic [KW-1:0]            fill_next;
  logic [KW-1:0]            cnt;
  logic [KW-1:0]            k_eff;
  logic [CW-1:0]            ws_ext;
  logic [RANK_W-1:0]        lo_rank;
  logic [RANK_W-1:0]        hi_rank;
  logic                     result_due;
  logic                     in_acc;
  logic                     out_free;
  logic                     out_load;
  logic                     out_valid;
  logic signed [OW-1:0]     out_median;
  swm_cell_ctl_t            ctl;

  logic signed [SAMPLE_BITS-1:0] win_c [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] fwd_c [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] bwd_c [MAX_WINDOW];
  logic                          fwd_ok_c [MAX_WINDOW];
  logic                          bwd_ok_c [MAX_WINDOW];
  logic signed [OW-1:0]          acc_c [MAX_WINDOW];
  logic                          mem_c [MAX_WINDOW];

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_WINDOW_SIZE) ? 32'(window_size) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WINDOW_SIZE_RST;
    end else if (psel && penable && pwrite && paddr[2] == REG_WINDOW_SIZE) begin
      window_size <= pwdata[WINDOW_SIZE_W-1:0];
    end
  end

  // A size of zero acts as one; sizes above the chain length saturate.
  assign ws_ext = CW'(window_size);
  always_comb begin
    if (ws_ext == '0) begin
      k_eff = KW'(1);
    end else if (ws_ext > CW'(MAX_WINDOW)) begin
      k_eff = KW'(MAX_WINDOW);
    end else begin
      k_eff = KW'(ws_ext);
    end
  end

  assign lo_rank = RANK_W'((k_eff - KW'(1)) >> 1);
  assign hi_rank = RANK_W'(k_eff >> 1);

  assign in_acc     = in_ch.valid && in_ch.ready;
  assign fill_next  = in_ch.start_req ? KW'(1) :
                      (fill_count < KW'(MAX_WINDOW)) ? fill_count + KW'(1) : fill_count;
  assign result_due = fill_next >= k_eff;
  assign out_free   = !out_valid || out_ch.ready;

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc && result_due) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_next = (k_eff == KW'(1)) ? ST_COLLECT : ST_RANK;
      end
      ST_RANK: begin
        if (cnt == k_eff - KW'(1)) begin
          state_next = ST_COLLECT;
        end
      end
      ST_COLLECT: begin
        if (cnt == k_eff) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = 1'b0;
    ctl         = '0;
    out_load    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        ctl.shift   = in_ch.valid;
      end
      ST_LOAD:    ctl.load    = 1'b1;
      ST_RANK:    ctl.rank    = 1'b1;
      ST_COLLECT: ctl.collect = 1'b1;
      ST_DONE:    out_load    = out_free;
      default:    ctl         = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      fill_count <= '0;
      cnt        <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (in_acc) begin
        fill_count <= fill_next;
      end
      if (state == ST_LOAD || (state == ST_RANK && state_next == ST_COLLECT)) begin
        cnt <= KW'(1);
      end else if (state == ST_RANK || state == ST_COLLECT) begin
        cnt <= cnt + KW'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_median <= acc_c[0];
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.median_twice = out_median;

  // Cell j holds the sample that is j items old.
  for (genvar j = 0; j < MAX_WINDOW; j++) begin : g_cell
    localparam logic [KW-1:0] IDX = KW'(j);

    assign mem_c[j] = IDX < k_eff;

    if (j == 0 && MAX_WINDOW == 1) begin : g_only
      swm_cell #(.SAMPLE_BITS(SAMPLE_BITS), .RANK_W(RANK_W)) u_cell (
        .clk, .ctl, .mem(mem_c[j]), .lo_rank, .hi_rank,
        .left_win(in_ch.sample), .left_mem(1'b0),
        .left_fwd('0), .left_fwd_ok(1'b0),
        .right_win('0), .right_mem(1'b0),
        .right_bwd('0), .right_bwd_ok(1'b0), .right_acc('0),
        .win(win_c[j]), .fwd(fwd_c[j]), .fwd_ok(fwd_ok_c[j]),
        .bwd(bwd_c[j]), .bwd_ok(bwd_ok_c[j]), .acc(acc_c[j])
      );
    end else if (j == 0) begin : g_first
      swm_cell #(.SAMPLE_BITS(SAMPLE_BITS), .RANK_W(RANK_W)) u_cell (
        .clk, .ctl, .mem(mem_c[j]), .lo_rank, .hi_rank,
        .left_win(in_ch.sample), .left_mem(1'b0),
        .left_fwd('0), .left_fwd_ok(1'b0),
        .right_win(win_c[j+1]), .right_mem(mem_c[j+1]),
        .right_bwd(bwd_c[j+1]), .right_bwd_ok(bwd_ok_c[j+1]),
        .right_acc(acc_c[j+1]),
        .win(win_c[j]), .fwd(fwd_c[j]), .fwd_ok(fwd_ok_c[j]),
        .bwd(bwd_c[j]), .bwd_ok(bwd_ok_c[j]), .acc(acc_c[j])
      );
    end else if (j == MAX_WINDOW - 1) begin : g_last
      swm_cell #(.SAMPLE_BITS(SAMPLE_BITS), .RANK_W(RANK_W)) u_cell (
        .clk, .ctl, .mem(mem_c[j]), .lo_rank, .hi_rank,
        .left_win(win_c[j-1]), .left_mem(mem_c[j-1]),
        .left_fwd(fwd_c[j-1]), .left_fwd_ok(fwd_ok_c[j-1]),
        .right_win('0), .right_mem(1'b0),
        .right_bwd('0), .right_bwd_ok(1'b0), .right_acc('0),
        .win(win_c[j]), .fwd(fwd_c[j]), .fwd_ok(fwd_ok_c[j]),
        .bwd(bwd_c[j]), .bwd_ok(bwd_ok_c[j]), .acc(acc_c[j])
      );
    end else begin : g_mid
      swm_cell #(.SAMPLE_BITS(SAMPLE_BITS), .RANK_W(RANK_W)) u_cell (
        .clk, .ctl, .mem(mem_c[j]), .lo_rank, .hi_rank,
        .left_win(win_c[j-1]), .left_mem(mem_c[j-1]),
        .left_fwd(fwd_c[j-1]), .left_fwd_ok(fwd_ok_c[j-1]),
        .right_win(win_c[j+1]), .right_mem(mem_c[j+1]),
        .right_bwd(bwd_c[j+1]), .right_bwd_ok(bwd_ok_c[j+1]),
        .right_acc(acc_c[j+1]),
        .win(win_c[j]), .fwd(fwd_c[j]), .fwd_ok(fwd_ok_c[j]),
        .bwd(bwd_c[j]), .bwd_ok(bwd_ok_c[j]), .acc(acc_c[j])
      );
    end
  end

  // An item that completes no window leaves the sequencer idle.
  `SWM_ASSERT_NXT(a_no_result_idle, in_acc && !result_due, state == ST_IDLE, "item without result started a median pass")
  // A one-sample window needs no rank steps.
  `SWM_ASSERT_NXT(a_k1_skips_rank, state == ST_LOAD && k_eff == KW'(1), state == ST_COLLECT, "single-sample window entered rank steps")
  // A new result appears only from the handover state.
  `SWM_ASSERT_IMP(a_out_from_done, $rose(out_valid), $past(state == ST_DONE), "result appeared outside handover")
  // The sum chain never runs past the window.
  `SWM_ASSERT_IMP(a_collect_bound, state == ST_COLLECT, cnt <= k_eff, "sum chain ran past the window")

endmodule
